// ===== rtl/radiance_average_gamma_to_rgb8_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the radiance average to gamma RGB8 block
// Same-cycle and next-cycle implication checks on the block clock.
// ---------------------------------------------------------------------------
`ifndef RADIANCE_AVERAGE_GAMMA_TO_RGB8_ASSERT_SVH
`define RADIANCE_AVERAGE_GAMMA_TO_RGB8_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RAG8_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define RAG8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rag8_pkg.sv =====
// ---------------------------------------------------------------------------
// rag8_pkg
// Types, constants and the gamma threshold function for the RGB8 converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rag8_pkg;

    localparam int LUT_INDEX_BITS_DEF = 12;
    localparam int SUM_W              = 32;
    localparam int BYTE_W             = 8;
    localparam int NUM_CH             = 3;
    localparam int GAMMA_STEPS        = 8;
    localparam int GAMMA_LEVELS       = 256;
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_TOP = 8'h80;

    typedef struct packed {
        logic signed [SUM_W-1:0] red_sum;
        logic signed [SUM_W-1:0] green_sum;
        logic signed [SUM_W-1:0] blue_sum;
        logic        [SUM_W-1:0] weight;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] red_byte;
        logic [BYTE_W-1:0] green_byte;
        logic [BYTE_W-1:0] blue_byte;
    } t_pix_out;

    typedef struct packed {
        logic              valid;
        logic [NUM_CH-1:0] zero;
        logic [NUM_CH-1:0] full;
    } t_ch_ctl;

    // Smallest index whose gamma byte reaches v.
    function automatic logic [16:0] rag8_threshold(input int v, input int idx_bits);
        logic [199:0] rhs;
        logic [199:0] lhs;
        int lo;
        int hi;
        int mid;
        int k;
        rhs = 200'(1);
        for (k = 0; k < 11; k++) begin
            rhs = rhs * 200'(v);
        end
        rhs = rhs << (5 * idx_bits);
        lo = 0;
        hi = 1 << idx_bits;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            lhs = 200'(1);
            for (k = 0; k < 5; k++) begin
                lhs = lhs * 200'(mid);
            end
            for (k = 0; k < 11; k++) begin
                lhs = lhs * 200'(255);
            end
            if (lhs >= rhs) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 17'(lo);
    endfunction

endpackage

// ===== rtl/radiance_average_gamma_to_rgb8.sv =====
// ---------------------------------------------------------------------------
// radiance_average_gamma_to_rgb8
// Radiance sum average, clamp and 1/2.2 gamma to 8-bit RGB, one pixel a clock.
// ---------------------------------------------------------------------------
// A pixel is taken on every clock that start is high; busy is always low.
// Its bytes appear on o_pix with o_strobe in order, with no way to hold them
// off: one register classifies the channels, LUT_INDEX_BITS divider stages
// produce one quotient bit each, eight stages search the gamma threshold
// table one output bit each, and one register drives the outputs.
`timescale 1ns / 1ps

module radiance_average_gamma_to_rgb8 #(
    parameter int LUT_INDEX_BITS = rag8_pkg::LUT_INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rag8_pkg::t_pix_in     i_pix,
    output logic                  o_strobe,
    output rag8_pkg::t_pix_out    o_pix
);
    import rag8_pkg::*;

    t_ch_ctl                   w_ctl;
    logic [LUT_INDEX_BITS-1:0] w_idx [NUM_CH];

    assign busy = 1'b0;

    rag8_divider #(
        .IDX_BITS (LUT_INDEX_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_pix   (i_pix),
        .o_ctl   (w_ctl),
        .o_idx   (w_idx)
    );

    rag8_gamma #(
        .IDX_BITS (LUT_INDEX_BITS)
    ) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_idx   (w_idx),
        .o_valid (o_strobe),
        .o_pix   (o_pix)
    );

endmodule

// ===== rtl/rag8_divider.sv =====
// ---------------------------------------------------------------------------
// rag8_divider
// Classify channels, then restoring division, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rag8_divider #(
    parameter int IDX_BITS = rag8_pkg::LUT_INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rag8_pkg::t_pix_in     i_pix,
    output rag8_pkg::t_ch_ctl     o_ctl,
    output logic [IDX_BITS-1:0]   o_idx [rag8_pkg::NUM_CH]
);
    import rag8_pkg::*;

    logic [SUM_W-1:0]    w_sum [NUM_CH];
    logic [SUM_W-1:0]    r_rem [0:IDX_BITS][NUM_CH];
    logic [IDX_BITS-1:0] r_q   [0:IDX_BITS][NUM_CH];
    logic [SUM_W-1:0]    r_w   [0:IDX_BITS];
    t_ch_ctl             r_ctl [0:IDX_BITS];
    t_ch_ctl             n_ctl;

    assign w_sum[0] = i_pix.red_sum;
    assign w_sum[1] = i_pix.green_sum;
    assign w_sum[2] = i_pix.blue_sum;

    always_comb begin
        n_ctl.valid = i_valid;
        for (int c = 0; c < NUM_CH; c++) begin
            n_ctl.zero[c] = (i_pix.weight == '0) || w_sum[c][SUM_W-1] || (w_sum[c] == '0);
            n_ctl.full[c] = !n_ctl.zero[c] && (w_sum[c] >= i_pix.weight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w[0] <= i_pix.weight;
        for (int c = 0; c < NUM_CH; c++) begin
            r_rem[0][c] <= w_sum[c];
            r_q[0][c]   <= '0;
        end
    end

    for (genvar s = 0; s < IDX_BITS; s++) begin : g_div
        for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
            logic [SUM_W:0]      w_shift;
            logic                w_ge;
            logic [SUM_W-1:0]    n_rem;
            logic [IDX_BITS-1:0] n_q;

            always_comb begin
                w_shift = {r_rem[s][c], 1'b0};
                w_ge    = w_shift >= {1'b0, r_w[s]};
                n_rem   = w_ge ? SUM_W'(w_shift - {1'b0, r_w[s]}) : w_shift[SUM_W-1:0];
                n_q     = {r_q[s][c][IDX_BITS-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                r_rem[s+1][c] <= n_rem;
                r_q[s+1][c]   <= n_q;
            end
        end

        always_ff @(posedge i_clk) begin
            r_w[s+1] <= r_w[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s+1] <= '0;
            end else begin
                r_ctl[s+1] <= r_ctl[s];
            end
        end
    end

    assign o_ctl = r_ctl[IDX_BITS];
    assign o_idx = r_q[IDX_BITS];

endmodule

// ===== rtl/rag8_gamma.sv =====
// ---------------------------------------------------------------------------
// rag8_gamma
// Gamma curve by bitwise search over a threshold table, one bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rag8_gamma #(
    parameter int IDX_BITS = rag8_pkg::LUT_INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rag8_pkg::t_ch_ctl     i_ctl,
    input  logic [IDX_BITS-1:0]   i_idx [rag8_pkg::NUM_CH],
    output logic                  o_valid,
    output rag8_pkg::t_pix_out    o_pix
);
    import rag8_pkg::*;

    logic [IDX_BITS:0]   thr   [GAMMA_LEVELS];
    logic [BYTE_W-1:0]   r_v   [1:GAMMA_STEPS][NUM_CH];
    logic [IDX_BITS-1:0] r_idx [1:GAMMA_STEPS][NUM_CH];
    t_ch_ctl             r_ctl [1:GAMMA_STEPS];
    logic [BYTE_W-1:0]   n_byte [NUM_CH];
    logic                r_valid;
    t_pix_out            r_pix;

    for (genvar v = 0; v < GAMMA_LEVELS; v++) begin : g_thr
        localparam logic [IDX_BITS:0] THR = (IDX_BITS + 1)'(rag8_threshold(v, IDX_BITS));
        assign thr[v] = THR;
    end

    for (genvar k = 0; k < GAMMA_STEPS; k++) begin : g_step
        logic [BYTE_W-1:0]   w_v   [NUM_CH];
        logic [IDX_BITS-1:0] w_idx [NUM_CH];
        t_ch_ctl             w_ctl;

        if (k == 0) begin : g_first
            assign w_ctl = i_ctl;
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign w_v[c]   = '0;
                assign w_idx[c] = i_idx[c];
            end
        end else begin : g_rest
            assign w_ctl = r_ctl[k];
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign w_v[c]   = r_v[k][c];
                assign w_idx[c] = r_idx[k][c];
            end
        end

        for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
            logic [BYTE_W-1:0] w_cand;
            logic [BYTE_W-1:0] n_v;

            always_comb begin
                w_cand = w_v[c] | (BYTE_TOP >> k);
                n_v    = (thr[w_cand] <= {1'b0, w_idx[c]}) ? w_cand : w_v[c];
            end

            always_ff @(posedge i_clk) begin
                r_v[k+1][c]   <= n_v;
                r_idx[k+1][c] <= w_idx[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else begin
                r_ctl[k+1] <= w_ctl;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_ctl[GAMMA_STEPS].zero[c]) begin
                n_byte[c] = '0;
            end else if (r_ctl[GAMMA_STEPS].full[c]) begin
                n_byte[c] = BYTE_MAX;
            end else begin
                n_byte[c] = r_v[GAMMA_STEPS][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl[GAMMA_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix.red_byte   <= n_byte[0];
        r_pix.green_byte <= n_byte[1];
        r_pix.blue_byte  <= n_byte[2];
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ===== rtl/rag8_checker.sv =====
// ---------------------------------------------------------------------------
// rag8_checker
// Port-level checks of the RGB8 converter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radiance_average_gamma_to_rgb8_assert.svh"

module rag8_checker #(
    parameter int LUT_INDEX_BITS = rag8_pkg::LUT_INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  rag8_pkg::t_pix_in     i_pix,
    input  logic                  o_strobe,
    input  rag8_pkg::t_pix_out    o_pix
);
    import rag8_pkg::*;

    localparam int LAT = LUT_INDEX_BITS + 10;

    logic w_zero_w;
    logic w_red_full;

    assign w_zero_w   = start && (i_pix.weight == '0);
    assign w_red_full = start && (i_pix.weight != '0) && !i_pix.red_sum[SUM_W-1]
                        && ({1'b0, i_pix.red_sum[SUM_W-2:0]} >= i_pix.weight);

    `RAG8_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

    `RAG8_ASSERT_IMPL(a_no_phantom, o_strobe, $past(start, LAT), "beat without a pixel")

    `RAG8_ASSERT_IMPL(a_zero_weight, o_strobe && $past(w_zero_w, LAT), o_pix == '0, "zero weight not black")

    `RAG8_ASSERT_IMPL(a_red_sat, o_strobe && $past(w_red_full, LAT), o_pix.red_byte == BYTE_MAX, "red not saturated")

endmodule

bind radiance_average_gamma_to_rgb8 rag8_checker #(
    .LUT_INDEX_BITS (LUT_INDEX_BITS)
) u_rag8_checker (.*);
